// ===== sv/tea_pkg.sv =====
// Package for the TEA block cipher: constants, payload and key types, round function.
// Used by every module of the block; depends on nothing else.

package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NUM_CELLS = 2 * ROUNDS;

  localparam logic [31:0] DELTA        = 32'h9e37_79b9;
  localparam logic [31:0] DEC_SUM_INIT = 32'(64'(DELTA) * 64'(ROUNDS));

  localparam int unsigned CFG_AW = 4;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } tea_reg_idx_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } tea_in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } tea_out_t;

  typedef struct packed {
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
  } tea_key_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] sum;
  } tea_stage_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = (x << 4) + ka;
    b = x + sum;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// ===== sv/tea_cfg.sv =====
// APB-style key register file for the TEA block cipher.
// Depends on tea_pkg for the register indexes and the key type.

module tea_cfg
  import tea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output tea_key_t          key
);

  tea_key_t     key_r;
  tea_reg_idx_t idx;
  logic         wr_en;

  assign idx        = tea_reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign key        = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_WORD0: key_r.key_word0 <= cfg_pwdata;
        REG_KEY_WORD1: key_r.key_word1 <= cfg_pwdata;
        REG_KEY_WORD2: key_r.key_word2 <= cfg_pwdata;
        REG_KEY_WORD3: key_r.key_word3 <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_WORD0: cfg_prdata = key_r.key_word0;
      REG_KEY_WORD1: cfg_prdata = key_r.key_word1;
      REG_KEY_WORD2: cfg_prdata = key_r.key_word2;
      REG_KEY_WORD3: cfg_prdata = key_r.key_word3;
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

// ===== sv/tea_cell.sv =====
// One half-round cell of the TEA pipeline: updates one word of the block and the running sum.
// Depends on tea_pkg for the stage type and the round function.

module tea_cell
  import tea_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       second_half,
  input  tea_key_t   key,
  input  tea_stage_t d,
  output tea_stage_t q
);

  tea_stage_t  q_r;
  tea_stage_t  q_nxt;
  logic        upd_first;
  logic [31:0] x;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] f;

  // Encryption updates the first word in the first half; decryption in the second half.
  assign upd_first = (d.kind == second_half);
  assign x         = upd_first ? d.w1 : d.w0;
  assign ka        = upd_first ? key.key_word0 : key.key_word2;
  assign kb        = upd_first ? key.key_word1 : key.key_word3;
  assign f         = tea_mix(x, d.sum, ka, kb);

  always_comb begin
    q_nxt = d;
    if (upd_first) begin
      q_nxt.w0 = (d.kind == KIND_DECRYPT) ? d.w0 - f : d.w0 + f;
    end else begin
      q_nxt.w1 = (d.kind == KIND_DECRYPT) ? d.w1 - f : d.w1 + f;
    end
    if (second_half) begin
      q_nxt.sum = (d.kind == KIND_DECRYPT) ? d.sum - DELTA : d.sum + DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      q_r.kind <= q_nxt.kind;
      q_r.w0   <= q_nxt.w0;
      q_r.w1   <= q_nxt.w1;
      q_r.sum  <= q_nxt.sum;
    end
  end

  assign q = q_r;

endmodule

// ===== sv/tea_block_cipher_top.sv =====
// Top level of the TEA block cipher: key registers, a chain of half-round cells, output skid.
// Depends on tea_pkg, tea_cfg and tea_cell.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | tea_in_t  (kind, word_first, word_second)
//   out_    | output    | out_valid/out_stall| tea_out_t (result_first, result_second)
//   cfg_    | input     | APB write/read     | key_word0..key_word3 at 0x0, 0x4, 0x8, 0xC
//
// One block is accepted per cycle while in_stall is low; each result passes through the chain
// of 2*ROUNDS half-round cells and then the output register.
// Reset is synchronous and clears all valid bits and the key registers.
// A stalled result is held in the output register and the next one in a skid register; in_stall
// rises only when the skid register is full, and then the whole chain holds.

module tea_block_cipher_top
  import tea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tea_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tea_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  tea_key_t   key;
  tea_stage_t chain [NUM_CELLS+1];
  tea_stage_t last;
  logic       adv;
  logic       take;
  logic       out_free;

  logic       out_valid_r;
  tea_out_t   out_data_r;
  logic       skid_valid_r;
  tea_out_t   skid_data_r;

  tea_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .key         (key)
  );

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].kind  = in_data.kind;
    chain[0].w0    = in_data.word_first;
    chain[0].w1    = in_data.word_second;
    chain[0].sum   = (in_data.kind == KIND_DECRYPT) ? DEC_SUM_INIT : DELTA;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tea_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (adv),
      .second_half ((i % 2) == 1),
      .key         (key),
      .d           (chain[i]),
      .q           (chain[i+1])
    );
  end

  assign last     = chain[NUM_CELLS];
  assign take     = adv && last.valid;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (take) begin
        out_data_r.result_first  <= last.w0;
        out_data_r.result_second <= last.w1;
      end
    end else if (take) begin
      skid_data_r.result_first  <= last.w0;
      skid_data_r.result_second <= last.w1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && last.valid) |=> (last.valid && $stable(last.w0) && $stable(last.w1)))
    else $error("last cell changed while the chain was held");

endmodule

// ===== sim/tea_result_checker.sv =====
// Checker for the TEA block cipher: watches the input, result and register ports of the block.
// It predicts every result from its own copy of the key and compares them in order.
// Depends on tea_pkg for the payload, key and register index types.

module tea_result_checker
  import tea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tea_in_t           in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tea_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                pending,
  output int                checked
);

  tea_key_t key_copy;
  tea_out_t expected_blocks[$];

  function automatic tea_out_t tea_expected_block(input tea_in_t blk, input tea_key_t key);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] acc;
    tea_out_t    res;
    v0 = blk.word_first;
    v1 = blk.word_second;
    if (blk.kind == KIND_ENCRYPT) begin
      acc = 32'h0;
      for (int r = 0; r < ROUNDS; r++) begin
        acc = acc + DELTA;
        v0 = v0 + (((v1 << 4) + key.key_word0) ^ (v1 + acc) ^ ((v1 >> 5) + key.key_word1));
        v1 = v1 + (((v0 << 4) + key.key_word2) ^ (v0 + acc) ^ ((v0 >> 5) + key.key_word3));
      end
    end else begin
      acc = DELTA * 32'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        v1 = v1 - (((v0 << 4) + key.key_word2) ^ (v0 + acc) ^ ((v0 >> 5) + key.key_word3));
        v0 = v0 - (((v1 << 4) + key.key_word0) ^ (v1 + acc) ^ ((v1 >> 5) + key.key_word1));
        acc = acc - DELTA;
      end
    end
    res.result_first  = v0;
    res.result_second = v1;
    return res;
  endfunction

  task automatic check_word(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $realtime);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    tea_out_t     want;
    logic [31:0]  stored;
    tea_reg_idx_t idx;
    if (!rst_n) begin
      key_copy = '0;
      expected_blocks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %h at %0t", out_data, $realtime);
          end
        end else begin
          want = expected_blocks.pop_front();
          check_word("result_first", want.result_first, out_data.result_first);
          check_word("result_second", want.result_second, out_data.result_second);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(tea_expected_block(in_data, key_copy));
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        idx = tea_reg_idx_t'(cfg_paddr[3:2]);
        if (cfg_pwrite) begin
          case (idx)
            REG_KEY_WORD0: key_copy.key_word0 = cfg_pwdata;
            REG_KEY_WORD1: key_copy.key_word1 = cfg_pwdata;
            REG_KEY_WORD2: key_copy.key_word2 = cfg_pwdata;
            default:       key_copy.key_word3 = cfg_pwdata;
          endcase
        end else begin
          case (idx)
            REG_KEY_WORD0: stored = key_copy.key_word0;
            REG_KEY_WORD1: stored = key_copy.key_word1;
            REG_KEY_WORD2: stored = key_copy.key_word2;
            default:       stored = key_copy.key_word3;
          endcase
          check_word("key register read", stored, cfg_prdata);
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the TEA block cipher: clock, reset, block and key stimulus, and the verdict.
// Depends on tea_pkg, tea_block_cipher_top and tea_result_checker.

module tb;
  import tea_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 2 * ROUNDS + 16;
  localparam int PHASE_BLOCKS = 192;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  tea_in_t           in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  tea_out_t          out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int mismatches;
  int pending;
  int checked;

  logic bulk_traffic = 1'b0;
  int   long_holds   = 0;
  int   enc_sent     = 0;
  int   dec_sent     = 0;
  int   held_cycles  = 0;
  int   key_settings = 1;

  tea_block_cipher_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tea_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("** tea_block_cipher_top: FAILED **");
    $finish;
  end

  // The receiver mixes free-flowing, heavily stalled and lightly stalled stretches; during bulk
  // traffic it sometimes refuses results for a long time so the pipeline fills up.
  initial begin : receiver
    int mode;
    int span;
    @(posedge rst_n);
    forever begin
      if (bulk_traffic && (long_holds == 0 || $urandom_range(0, 59) == 0)) begin
        long_holds++;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 80);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  task automatic cfg_access(input tea_reg_idx_t idx, input logic write, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    cfg_access(REG_KEY_WORD0, 1'b1, k0);
    cfg_access(REG_KEY_WORD1, 1'b1, k1);
    cfg_access(REG_KEY_WORD2, 1'b1, k2);
    cfg_access(REG_KEY_WORD3, 1'b1, k3);
    for (int i = 0; i < 4; i++) cfg_access(tea_reg_idx_t'(i), 1'b0, 32'h0);
    key_settings++;
  endtask

  task automatic send_block(input tea_in_t blk);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= blk;
    @(posedge clk);
    while (in_stall) begin
      held_cycles++;
      @(posedge clk);
    end
    if (blk.kind == KIND_DECRYPT) dec_sent++;
    else enc_sent++;
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic tea_in_t random_block();
    tea_in_t blk;
    blk.kind        = $urandom_range(0, 1) ? KIND_DECRYPT : KIND_ENCRYPT;
    blk.word_first  = pick_word();
    blk.word_second = pick_word();
    return blk;
  endfunction

  task automatic send_traffic(input int count);
    int left;
    int burst;
    left = count;
    bulk_traffic = 1'b1;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_block(random_block());
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(0, 12));
    end
    idle_input(0);
    bulk_traffic = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] edge_words[8][2];
    tea_in_t     blk;
    edge_words = '{'{32'h0000_0000, 32'h0000_0000}, '{32'hffff_ffff, 32'hffff_ffff},
                   '{32'h0000_0000, 32'hffff_ffff}, '{32'hffff_ffff, 32'h0000_0000},
                   '{32'h8000_0000, 32'h0000_0001}, '{32'h0000_0001, 32'h8000_0000},
                   '{32'haaaa_aaaa, 32'h5555_5555}, '{32'h0123_4567, 32'h89ab_cdef}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 4; i++) cfg_access(tea_reg_idx_t'(i), 1'b0, 32'h0);
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 2; k++) begin
        blk.kind        = k ? KIND_DECRYPT : KIND_ENCRYPT;
        blk.word_first  = edge_words[i][0];
        blk.word_second = edge_words[i][1];
        send_block(blk);
      end
    end
    idle_input(0);
    drain();

    load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_traffic(PHASE_BLOCKS);
    drain();
    load_key(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'hffff_fffe);
    send_traffic(PHASE_BLOCKS);
    for (int p = 0; p < 3; p++) begin
      drain();
      load_key($urandom(), $urandom(), $urandom(), $urandom());
      send_traffic(PHASE_BLOCKS);
    end
    drain();
    load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_traffic(PHASE_BLOCKS);
    drain();

    $display("Sent %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings, %0d checked.",
             enc_sent + dec_sent, enc_sent, dec_sent, key_settings, checked);
    $display("Input was held back for %0d cycles over %0d long result hold-offs.",
             held_cycles, long_holds);
    if (mismatches == 0 && pending == 0) begin
      $display("** tea_block_cipher_top: PASSED **");
    end else begin
      $display("** tea_block_cipher_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tea_pkg.sv
sv/tea_cfg.sv
sv/tea_cell.sv
sv/tea_block_cipher_top.sv
sim/tea_result_checker.sv
sim/tb.sv
